// ===== src/slu_pkg.sv =====
package slu_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_BODY    = 4'd1,
		PH_ESC     = 4'd2,
		PH_HEX_HI  = 4'd3,
		PH_PAIR_BS = 4'd4,
		PH_PAIR_U  = 4'd5,
		PH_HEX_LO  = 4'd6,
		PH_DONE    = 4'd7,
		PH_ERR     = 4'd8
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_literal;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic       error;
	} out_item_t;

	// One classified input byte: up to four decoded bytes, or the close of a literal.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      n_m1;
		logic            mode;
		logic            last;
		logic            err;
	} cmd_t;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_UPPER_N = 8'h4E;
	localparam logic [7:0] CH_LOWER_U = 8'h75;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_LOWER_N = 8'h6E;
	localparam logic [7:0] CH_LOWER_R = 8'h72;
	localparam logic [7:0] CH_LOWER_T = 8'h74;
	localparam logic [7:0] CH_BS      = 8'h08;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_TAB     = 8'h09;

	localparam logic [15:0] SURR_HI_MIN = 16'hD800;
	localparam logic [15:0] SURR_HI_MAX = 16'hDBFF;
	localparam logic [20:0] PAIR_BASE   = 21'h10000;
	localparam logic [20:0] CP_1B_MAX   = 21'h7F;
	localparam logic [20:0] CP_2B_MAX   = 21'h7FF;
	localparam logic [20:0] CP_3B_MAX   = 21'hFFFF;
	localparam logic [7:0]  LEAD_2B     = 8'hC0;
	localparam logic [7:0]  LEAD_3B     = 8'hE0;
	localparam logic [7:0]  LEAD_4B     = 8'hF0;
	localparam logic [7:0]  CONT_BYTE   = 8'h80;

	localparam int CLASS_LEN = 10;
	localparam int SPACE_LEN = 3;

	localparam logic [7:0] DIGIT_CLASS [CLASS_LEN] = '{
		8'h5B, 8'h30, 8'h2D, 8'h39, 8'h5C, 8'h2E, 8'h2C, 8'h2D, 8'h5D, 8'h2B
	};

	localparam logic [7:0] SPACE_SEQ [SPACE_LEN] = '{8'h5C, 8'h73, 8'h2B};

	// Bit 4 set means not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

endpackage

// ===== src/string_literal_unescape_utf8_top.sv =====
// Unescapes a quoted string or regex literal arriving one byte per transaction
// and returns its UTF-8 bytes, one per result transaction, closed by a last
// result that carries the error flag. Input bytes are accepted one per cycle
// while the four-entry command queue between the classifier and the emitter
// has room; the emitter returns one result per cycle unless res_stall holds it,
// so a byte that expands (a \u escape into up to four UTF-8 bytes, a regex
// space into three, %N into ten) stalls the input once the queue fills. The
// user must write regex_mode only while no literal is in flight; the block
// does not enforce it, and the write port is always ready.
module string_literal_unescape_utf8_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  slu_pkg::in_item_t  item,
	output logic               res_valid,
	input  logic               res_stall,
	output slu_pkg::out_item_t res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);

	logic          q_full, accept, push, pop, head_valid;
	slu_pkg::cmd_t push_cmd, head;

	assign cfg_ready = 1'b1;

	slu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.q_full    (q_full),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	assign item_stall = !accept && q_full;

	slu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head      (head)
	);

	slu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== src/slu_front.sv =====
module slu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  slu_pkg::in_item_t item,
	input  logic            q_full,
	input  logic            cfg_valid,
	input  logic            cfg_data,
	output logic            accept,
	output logic            push,
	output slu_pkg::cmd_t   push_cmd
);

	slu_pkg::phase_t phase_q, phase_d;
	logic [15:0] hi_q, hi_d, lo_q, lo_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        mode_q;

	logic [7:0]  b;
	logic [4:0]  dig;
	logic [15:0] unit_new;
	logic [7:0]  esc_v;
	logic        esc_known;
	logic        unit_surr;

	function automatic slu_pkg::cmd_t utf8_cmd(input logic [20:0] cp, input logic mode);
		slu_pkg::cmd_t c;
		c = '0;
		c.mode = mode;
		if (cp <= slu_pkg::CP_1B_MAX) begin
			c.bytes[0] = cp[7:0];
			c.n_m1 = 2'd0;
		end else if (cp <= slu_pkg::CP_2B_MAX) begin
			c.bytes[0] = slu_pkg::LEAD_2B | {3'b0, cp[10:6]};
			c.bytes[1] = slu_pkg::CONT_BYTE | {2'b0, cp[5:0]};
			c.n_m1 = 2'd1;
		end else if (cp <= slu_pkg::CP_3B_MAX) begin
			c.bytes[0] = slu_pkg::LEAD_3B | {4'b0, cp[15:12]};
			c.bytes[1] = slu_pkg::CONT_BYTE | {2'b0, cp[11:6]};
			c.bytes[2] = slu_pkg::CONT_BYTE | {2'b0, cp[5:0]};
			c.n_m1 = 2'd2;
		end else begin
			c.bytes[0] = slu_pkg::LEAD_4B | {5'b0, cp[20:18]};
			c.bytes[1] = slu_pkg::CONT_BYTE | {2'b0, cp[17:12]};
			c.bytes[2] = slu_pkg::CONT_BYTE | {2'b0, cp[11:6]};
			c.bytes[3] = slu_pkg::CONT_BYTE | {2'b0, cp[5:0]};
			c.n_m1 = 2'd3;
		end
		return c;
	endfunction

	assign accept = item_valid && !q_full;
	assign b = item.in_byte;
	assign dig = slu_pkg::hex_value(b);
	assign unit_new = (phase_q == slu_pkg::PH_HEX_LO) ? {lo_q[11:0], dig[3:0]}
		: {hi_q[11:0], dig[3:0]};
	assign unit_surr = (unit_new >= slu_pkg::SURR_HI_MIN && unit_new <= slu_pkg::SURR_HI_MAX);

	always_comb begin
		esc_v = 8'h00;
		esc_known = 1'b1;
		case (b)
			slu_pkg::CH_SLASH:   esc_v = slu_pkg::CH_SLASH;
			slu_pkg::CH_LOWER_F: esc_v = slu_pkg::CH_FF;
			slu_pkg::CH_LOWER_N: esc_v = slu_pkg::CH_LF;
			slu_pkg::CH_LOWER_R: esc_v = slu_pkg::CH_CR;
			slu_pkg::CH_LOWER_T: esc_v = slu_pkg::CH_TAB;
			slu_pkg::CH_QUOTE: begin
				esc_v = slu_pkg::CH_QUOTE;
				esc_known = !mode_q;
			end
			slu_pkg::CH_BSLASH: begin
				esc_v = slu_pkg::CH_BSLASH;
				esc_known = !mode_q;
			end
			slu_pkg::CH_LOWER_B: begin
				esc_v = slu_pkg::CH_BS;
				esc_known = !mode_q;
			end
			default: esc_known = 1'b0;
		endcase
	end

	// Next state
	always_comb begin
		phase_d = phase_q;
		hi_d = hi_q;
		lo_d = lo_q;
		cnt_d = cnt_q;
		if (accept) begin
			if (item.end_of_literal) begin
				phase_d = slu_pkg::PH_IDLE;
				hi_d = '0;
				lo_d = '0;
				cnt_d = '0;
			end else begin
				case (phase_q)
					slu_pkg::PH_IDLE: phase_d = slu_pkg::PH_BODY;
					slu_pkg::PH_BODY: begin
						if (b == (mode_q ? slu_pkg::CH_SLASH : slu_pkg::CH_QUOTE)) begin
							phase_d = slu_pkg::PH_DONE;
						end else if (b == slu_pkg::CH_BSLASH) begin
							phase_d = slu_pkg::PH_ESC;
						end
					end
					slu_pkg::PH_ESC: begin
						if (b == slu_pkg::CH_LOWER_U) begin
							phase_d = slu_pkg::PH_HEX_HI;
							hi_d = '0;
							cnt_d = '0;
						end else if (esc_known || mode_q) begin
							phase_d = slu_pkg::PH_BODY;
						end else begin
							phase_d = slu_pkg::PH_ERR;
						end
					end
					slu_pkg::PH_HEX_HI, slu_pkg::PH_HEX_LO: begin
						if (dig[4]) begin
							phase_d = slu_pkg::PH_ERR;
						end else begin
							if (phase_q == slu_pkg::PH_HEX_HI) begin
								hi_d = unit_new;
							end else begin
								lo_d = unit_new;
							end
							if (cnt_q != 2'd3) begin
								cnt_d = cnt_q + 2'd1;
							end else begin
								cnt_d = '0;
								if (phase_q == slu_pkg::PH_HEX_HI && unit_surr) begin
									phase_d = slu_pkg::PH_PAIR_BS;
								end else begin
									phase_d = slu_pkg::PH_BODY;
								end
							end
						end
					end
					slu_pkg::PH_PAIR_BS: begin
						phase_d = (b == slu_pkg::CH_BSLASH) ? slu_pkg::PH_PAIR_U
							: slu_pkg::PH_ERR;
					end
					slu_pkg::PH_PAIR_U: begin
						if (b == slu_pkg::CH_LOWER_U) begin
							phase_d = slu_pkg::PH_HEX_LO;
							lo_d = '0;
							cnt_d = '0;
						end else begin
							phase_d = slu_pkg::PH_ERR;
						end
					end
					slu_pkg::PH_DONE, slu_pkg::PH_ERR: ;
					default: phase_d = slu_pkg::PH_ERR;
				endcase
			end
		end
	end

	// Command toward the queue
	always_comb begin
		push = 1'b0;
		push_cmd = '0;
		push_cmd.mode = mode_q;
		if (accept) begin
			if (item.end_of_literal) begin
				push = 1'b1;
				push_cmd.last = 1'b1;
				push_cmd.err = !(phase_q == slu_pkg::PH_BODY || phase_q == slu_pkg::PH_DONE);
			end else begin
				case (phase_q)
					slu_pkg::PH_BODY: begin
						if (b != (mode_q ? slu_pkg::CH_SLASH : slu_pkg::CH_QUOTE)
							&& b != slu_pkg::CH_BSLASH) begin
							push = 1'b1;
							push_cmd.bytes[0] = b;
						end
					end
					slu_pkg::PH_ESC: begin
						if (b == slu_pkg::CH_LOWER_U) begin
							push = 1'b0;
						end else if (esc_known) begin
							push = 1'b1;
							push_cmd.bytes[0] = esc_v;
						end else if (mode_q) begin
							// pass the unknown escape through, backslash first
							push = 1'b1;
							push_cmd.bytes[0] = slu_pkg::CH_BSLASH;
							push_cmd.bytes[1] = b;
							push_cmd.n_m1 = 2'd1;
						end
					end
					slu_pkg::PH_HEX_HI: begin
						if (!dig[4] && cnt_q == 2'd3 && !unit_surr) begin
							push = 1'b1;
							push_cmd = utf8_cmd({5'b0, unit_new}, mode_q);
						end
					end
					slu_pkg::PH_HEX_LO: begin
						if (!dig[4] && cnt_q == 2'd3) begin
							push = 1'b1;
							push_cmd = utf8_cmd(slu_pkg::PAIR_BASE
								+ {1'b0, hi_q[9:0], unit_new[9:0]}, mode_q);
						end
					end
					default: push = 1'b0;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slu_pkg::PH_IDLE;
			hi_q <= '0;
			lo_q <= '0;
			cnt_q <= '0;
			mode_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			hi_q <= hi_d;
			lo_q <= lo_d;
			cnt_q <= cnt_d;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
		end
	end

endmodule

// ===== src/slu_queue.sv =====
module slu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slu_pkg::cmd_t push_cmd,
	input  logic          pop,
	output logic          full,
	output logic          head_valid,
	output slu_pkg::cmd_t head
);

	slu_pkg::cmd_t entry_q [slu_pkg::QDEPTH];
	logic [slu_pkg::QAW-1:0] wr_q, rd_q;
	logic [slu_pkg::QAW:0]   count_q;

	assign full = (count_q == (slu_pkg::QAW+1)'(slu_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/slu_back.sv =====
module slu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  slu_pkg::cmd_t      head,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output slu_pkg::out_item_t res
);

	logic [1:0] k_q, k_d;
	logic [3:0] j_q, j_d;
	logic       pdone_q, pdone_d;
	logic       pend_q, pend_d;
	logic       res_valid_q;
	slu_pkg::out_item_t res_q;

	logic       out_ready, emit, adv, new_pend, ep;
	logic [7:0] b;
	slu_pkg::out_item_t o;

	assign out_ready = !res_valid_q || !res_stall;
	assign b = head.bytes[k_q];
	assign ep = pend_q && !pdone_q;

	always_comb begin
		emit = 1'b0;
		adv = 1'b0;
		new_pend = 1'b0;
		pop = 1'b0;
		o = '0;
		k_d = k_q;
		j_d = j_q;
		pdone_d = pdone_q;
		pend_d = pend_q;
		if (head_valid) begin
			if (head.last) begin
				emit = 1'b1;
				if (!head.err && ep) begin
					// flush the held percent before closing
					o.out_byte = slu_pkg::CH_PERCENT;
					o.byte_valid = 1'b1;
					if (out_ready) begin
						pdone_d = 1'b1;
					end
				end else begin
					o.last = 1'b1;
					o.error = head.err;
					if (out_ready) begin
						pop = 1'b1;
						pend_d = 1'b0;
						pdone_d = 1'b0;
						k_d = '0;
						j_d = '0;
					end
				end
			end else if (ep && b == slu_pkg::CH_UPPER_N) begin
				emit = 1'b1;
				o.out_byte = slu_pkg::DIGIT_CLASS[j_q];
				o.byte_valid = 1'b1;
				if (out_ready) begin
					if (j_q == 4'(slu_pkg::CLASS_LEN - 1)) begin
						adv = 1'b1;
					end else begin
						j_d = j_q + 4'd1;
					end
				end
			end else if (ep) begin
				emit = 1'b1;
				o.out_byte = slu_pkg::CH_PERCENT;
				o.byte_valid = 1'b1;
				if (out_ready) begin
					pdone_d = 1'b1;
				end
			end else if (head.mode && b == slu_pkg::CH_SPACE) begin
				emit = 1'b1;
				o.out_byte = slu_pkg::SPACE_SEQ[j_q[1:0]];
				o.byte_valid = 1'b1;
				if (out_ready) begin
					if (j_q == 4'(slu_pkg::SPACE_LEN - 1)) begin
						adv = 1'b1;
					end else begin
						j_d = j_q + 4'd1;
					end
				end
			end else if (head.mode && b == slu_pkg::CH_PERCENT) begin
				// hold the percent until the next decoded byte
				adv = 1'b1;
				new_pend = 1'b1;
			end else begin
				emit = 1'b1;
				o.out_byte = b;
				o.byte_valid = 1'b1;
				adv = out_ready;
			end
			if (adv) begin
				j_d = '0;
				pdone_d = 1'b0;
				pend_d = new_pend;
				if (k_q == head.n_m1) begin
					pop = 1'b1;
					k_d = '0;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			j_q <= '0;
			pdone_q <= 1'b0;
			pend_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			k_q <= k_d;
			j_q <= j_d;
			pdone_q <= pdone_d;
			pend_q <= pend_d;
			if (emit && out_ready) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_ready) begin
			res_q <= o;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

// ===== src/slu_checker.sv =====
module slu_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input slu_pkg::out_item_t res
);

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result changed while stalled");

	a_last_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> !res.byte_valid && res.out_byte == 8'h00)
		else $error("last result carries data");

	a_data_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> res.byte_valid && !res.error)
		else $error("data result malformed");

endmodule

bind string_literal_unescape_utf8_top slu_checker u_slu_checker (.*);
